// ----- rtl/tea_pkg.sv -----
// TEA block cipher: shared types, constants and the round mixing function.
// No dependencies; used by every module of the block.
package tea_pkg;

    localparam int          WORD_W      = 32;
    localparam int          ROUND_COUNT = 32;
    localparam logic [31:0] DELTA       = 32'h9e37_79b9;

    // Operation codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Configuration register indexes
    localparam int          CFG_INDEX_W   = 2;
    localparam logic [1:0]  REG_KEY_WORD0 = 2'd0;
    localparam logic [1:0]  REG_KEY_WORD1 = 2'd1;
    localparam logic [1:0]  REG_KEY_WORD2 = 2'd2;
    localparam logic [1:0]  REG_KEY_WORD3 = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word2;
        logic [WORD_W-1:0] word3;
    } key_t;

    // Payload carried down the round pipeline
    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } pipe_t;

    // Running sum after n additions of delta, modulo 2^32 (elaboration only)
    function automatic logic [31:0] round_sum(input int n);
        logic [63:0] prod;
        prod = 64'(DELTA) * 64'(n);
        return prod[31:0];
    endfunction

    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

// ----- rtl/tea_key_regs.sv -----
// TEA key register file: four 32-bit key words written over the config channel.
// Depends on tea_pkg.
module tea_key_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]      cfg_data,
    output tea_pkg::key_t                   key
);

    tea_pkg::key_t key_reg;
    tea_pkg::key_t key_next;

    assign cfg_ready = 1'b1;
    assign key       = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tea_pkg::REG_KEY_WORD0: key_next.word0 = cfg_data;
                tea_pkg::REG_KEY_WORD1: key_next.word1 = cfg_data;
                tea_pkg::REG_KEY_WORD2: key_next.word2 = cfg_data;
                tea_pkg::REG_KEY_WORD3: key_next.word3 = cfg_data;
                default:                key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

endmodule

// ----- rtl/tea_half_round.sv -----
// TEA half-round stage: one mix and one add/subtract, registered.
// Depends on tea_pkg.
module tea_half_round
#(
    parameter logic [31:0] ENC_SUM  = 32'h0,
    parameter logic [31:0] DEC_SUM  = 32'h0,
    parameter bit          SECOND   = 1'b0   // second half of a round
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  tea_pkg::key_t  key,
    input  logic           valid_in,
    input  tea_pkg::pipe_t data_in,
    output logic           valid_out,
    output tea_pkg::pipe_t data_out
);

    logic                      valid_reg;
    tea_pkg::pipe_t            data_reg;
    tea_pkg::pipe_t            data_next;
    logic                      update_a;
    logic [tea_pkg::WORD_W-1:0] x;
    logic [tea_pkg::WORD_W-1:0] ka;
    logic [tea_pkg::WORD_W-1:0] kb;
    logic [tea_pkg::WORD_W-1:0] sum;
    logic [tea_pkg::WORD_W-1:0] m;
    logic [tea_pkg::WORD_W-1:0] target;
    logic [tea_pkg::WORD_W-1:0] result;

    // Encrypt: first half updates a, second b. Decrypt runs the other way.
    always_comb
    begin
        update_a = (data_in.op == tea_pkg::OP_ENCRYPT) ? !SECOND : SECOND;
        x        = update_a ? data_in.b : data_in.a;
        ka       = update_a ? key.word0 : key.word2;
        kb       = update_a ? key.word1 : key.word3;
        target   = update_a ? data_in.a : data_in.b;
        sum      = (data_in.op == tea_pkg::OP_ENCRYPT) ? ENC_SUM : DEC_SUM;
        m        = tea_pkg::mix(x, sum, ka, kb);
        result   = (data_in.op == tea_pkg::OP_ENCRYPT) ? target + m : target - m;
        data_next    = data_in;
        if (update_a)
        begin
            data_next.a = result;
        end
        else
        begin
            data_next.b = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ----- rtl/tea_block_cipher.sv -----
// TEA block cipher top level: key registers and the unrolled half-round pipeline.
// Depends on tea_pkg, tea_key_regs and tea_half_round.
//
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+-------------------------------
// item in  | op, first_word, second_word             | start, taken when !busy
// item out | out_first_word, out_second_word         | done, one cycle, no back-pressure
// config   | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
// Each round is split into two register stages, one mix-and-add per stage,
// so the long adder chain sets the clock.
// One item enters every cycle; busy is never raised.
// Reset clears the valid bits of every stage and the key words to zero.
// The receiver cannot stall, so the pipeline never holds: each item leaves on done.
// Key words are read by all stages directly; write them only while no item is in flight.
module tea_block_cipher
#(
    parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // item in
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [tea_pkg::WORD_W-1:0]      first_word,
    input  logic [tea_pkg::WORD_W-1:0]      second_word,
    // item out
    output logic                            done,
    output logic [tea_pkg::WORD_W-1:0]      out_first_word,
    output logic [tea_pkg::WORD_W-1:0]      out_second_word,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]      cfg_data
);

    localparam int STAGES = 2 * ROUND_COUNT;

    tea_pkg::key_t  key;
    logic           stage_valid [0:STAGES];
    tea_pkg::pipe_t stage_data  [0:STAGES];

    tea_key_regs u_key_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // Fully pipelined, so an item is always taken
    assign busy = 1'b0;

    assign stage_valid[0]  = start && !busy;
    assign stage_data[0].op = op;
    assign stage_data[0].a  = first_word;
    assign stage_data[0].b  = second_word;

    // Encrypt round r uses delta*(r+1); decrypt round r uses delta*(ROUND_COUNT-r)
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int ROUND = s / 2;

        tea_half_round
        #(
            .ENC_SUM (tea_pkg::round_sum(ROUND + 1)),
            .DEC_SUM (tea_pkg::round_sum(ROUND_COUNT - ROUND)),
            .SECOND  ((s % 2) == 1)
        )
        u_half_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key),
            .valid_in  (stage_valid[s]),
            .data_in   (stage_data[s]),
            .valid_out (stage_valid[s+1]),
            .data_out  (stage_data[s+1])
        );
    end

    // Last stage is registered, so results come straight off it
    assign done            = stage_valid[STAGES];
    assign out_first_word  = stage_data[STAGES].a;
    assign out_second_word = stage_data[STAGES].b;

endmodule
